### src/ilte_pkg.sv
// ----------------------------------------------------------------------------
// ilte_pkg
// shared types and codes of the indexed list table engine
// ----------------------------------------------------------------------------
package ilte_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FuncW  = 3;

  // request codes carried on func
  typedef enum logic [FuncW-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_GET    = 3'd3,
    FUNC_SET    = 3'd4,
    FUNC_SEARCH = 3'd5,
    FUNC_SWAP   = 3'd6,
    FUNC_CLEAR  = 3'd7
  } func_e;

  typedef logic signed [ValueW-1:0] value_t;

  // read_value of a get that misses
  localparam value_t GetMissValue = -32'sd1;

endpackage

### src/indexed_list_table_engine_core.sv
// ----------------------------------------------------------------------------
// indexed_list_table_engine_core
// ordered list of signed 32-bit values in one ram, with a count
// ----------------------------------------------------------------------------
// The list lives in a single ram with one write port and one registered read
// port, so each request is one item at a time and data moves at one entry per
// cycle. Append, set, clear and failed requests go straight to S_DONE; get
// reads its entry, swap reads both entries and writes each over the other,
// insert shifts entries up from the tail and drops the value into the gap,
// remove shifts entries down, and search scans from the head to the first
// match or the end. The shifts of insert and remove and the scan of search are
// what make the cost grow with the list. in_stall_o is low only between
// requests; a finished result waits in the output register, so the next
// request can already run while the result is still stalled. The ram needs no
// clearing after reset: only entries below the count are ever read, and all
// of them were written.
// ----------------------------------------------------------------------------
module indexed_list_table_engine_core #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [ilte_pkg::FuncW-1:0]            func_i,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]      position_a_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]        position_b_i,
  input  logic signed [ilte_pkg::ValueW-1:0]    value_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  ok_o,
  output logic signed [ilte_pkg::ValueW-1:0]    read_value_o,
  output logic [$clog2(STORE_DEPTH)-1:0]        found_position_o,
  output logic [$clog2(STORE_DEPTH+1)-1:0]      count_now_o
);

  localparam int unsigned IdxW = $clog2(STORE_DEPTH);
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(STORE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_UP,  // insert: move entries up, highest first
    S_INS_W,     // insert: drop the new value into the gap
    S_SHIFT_DN,  // remove: move entries down, lowest first
    S_GET,
    S_SEARCH,
    S_SWAP_A,    // first entry arrives, second read issued
    S_SWAP_B,    // second entry arrives, written over the first
    S_SWAP_W,    // first entry written over the second
    S_DONE       // result waits for the output register
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        ptr_q, ptr_d;
  logic [IdxW-1:0]        end_q, end_d;
  ilte_pkg::value_t       val_q, val_d;
  ilte_pkg::value_t       tmp_q, tmp_d;
  logic                   res_ok_q, res_ok_d;
  ilte_pkg::value_t       res_rd_q, res_rd_d;
  logic [IdxW-1:0]        res_pos_q, res_pos_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_ok_q, out_ok_d;
  ilte_pkg::value_t       out_rd_q, out_rd_d;
  logic [IdxW-1:0]        out_pos_q, out_pos_d;
  logic [CntW-1:0]        out_cnt_q, out_cnt_d;

  // ram port
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  ilte_pkg::value_t       mem_wdata;
  logic                   mem_re;
  logic [IdxW-1:0]        mem_raddr;
  logic [ilte_pkg::ValueW-1:0] mem_rdata;

  ilte_pkg::func_e        func;
  logic [IdxW-1:0]        pa_idx;
  logic [CntW-1:0]        pb_cnt;
  logic                   out_free;

  assign func     = ilte_pkg::func_e'(func_i);
  assign pa_idx   = position_a_i[IdxW-1:0];
  assign pb_cnt   = CntW'(position_b_i);
  // output register can take a result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    res_ok_d    = res_ok_q;
    res_rd_d    = res_rd_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ok_d    = out_ok_q;
    out_rd_d    = out_rd_q;
    out_pos_d   = out_pos_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_ok_d  = 1'b0;
          res_rd_d  = '0;
          res_pos_d = '0;
          val_d     = value_i;
          state_d   = S_DONE;
          unique case (func)
            ilte_pkg::FUNC_APPEND: begin
              if (cnt_q != DepthC) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[IdxW-1:0];
                mem_wdata = value_i;
                cnt_d     = cnt_q + 1'b1;
                res_ok_d  = 1'b1;
              end
            end
            ilte_pkg::FUNC_INSERT: begin
              if (cnt_q != DepthC && position_a_i <= cnt_q) begin
                if (position_a_i == cnt_q) begin
                  // insert at the tail is an append
                  mem_we    = 1'b1;
                  mem_waddr = pa_idx;
                  mem_wdata = value_i;
                  cnt_d     = cnt_q + 1'b1;
                  res_ok_d  = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = IdxW'(cnt_q - 1'b1);
                  ptr_d     = IdxW'(cnt_q - 1'b1);
                  end_d     = pa_idx;
                  state_d   = S_SHIFT_UP;
                end
              end
            end
            ilte_pkg::FUNC_REMOVE: begin
              if (position_a_i < cnt_q) begin
                if (position_a_i == cnt_q - 1'b1) begin
                  // last entry goes, nothing to move
                  cnt_d    = cnt_q - 1'b1;
                  res_ok_d = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = pa_idx + 1'b1;
                  ptr_d     = pa_idx + 1'b1;
                  end_d     = IdxW'(cnt_q - 1'b1);
                  state_d   = S_SHIFT_DN;
                end
              end
            end
            ilte_pkg::FUNC_GET: begin
              if (position_a_i < cnt_q) begin
                mem_re    = 1'b1;
                mem_raddr = pa_idx;
                state_d   = S_GET;
              end else begin
                res_rd_d = ilte_pkg::GetMissValue;
              end
            end
            ilte_pkg::FUNC_SET: begin
              if (position_a_i < cnt_q) begin
                mem_we    = 1'b1;
                mem_waddr = pa_idx;
                mem_wdata = value_i;
                res_ok_d  = 1'b1;
              end
            end
            ilte_pkg::FUNC_SEARCH: begin
              if (cnt_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                end_d     = IdxW'(cnt_q - 1'b1);
                state_d   = S_SEARCH;
              end
            end
            ilte_pkg::FUNC_SWAP: begin
              if (position_a_i < cnt_q && pb_cnt < cnt_q) begin
                mem_re    = 1'b1;
                mem_raddr = pa_idx;
                ptr_d     = pa_idx;
                end_d     = position_b_i;
                state_d   = S_SWAP_A;
              end
            end
            ilte_pkg::FUNC_CLEAR: begin
              cnt_d    = '0;
              res_ok_d = 1'b1;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // entry ptr arrives and moves one place up
        mem_we    = 1'b1;
        mem_waddr = ptr_q + 1'b1;
        mem_wdata = mem_rdata;
        if (ptr_q == end_q) begin
          state_d = S_INS_W;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - 1'b1;
          ptr_d     = ptr_q - 1'b1;
        end
      end

      S_INS_W: begin
        mem_we    = 1'b1;
        mem_waddr = end_q;
        mem_wdata = val_q;
        cnt_d     = cnt_q + 1'b1;
        res_ok_d  = 1'b1;
        state_d   = S_DONE;
      end

      S_SHIFT_DN: begin
        // entry ptr arrives and moves one place down
        mem_we    = 1'b1;
        mem_waddr = ptr_q - 1'b1;
        mem_wdata = mem_rdata;
        if (ptr_q == end_q) begin
          cnt_d    = cnt_q - 1'b1;
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end
      end

      S_GET: begin
        res_rd_d = mem_rdata;
        res_ok_d = 1'b1;
        state_d  = S_DONE;
      end

      S_SEARCH: begin
        priority if (mem_rdata == val_q) begin
          res_ok_d  = 1'b1;
          res_pos_d = ptr_q;
          state_d   = S_DONE;
        end else if (ptr_q == end_q) begin
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + 1'b1;
          ptr_d     = ptr_q + 1'b1;
        end
      end

      S_SWAP_A: begin
        tmp_d     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = end_q;
        state_d   = S_SWAP_B;
      end

      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = mem_rdata;
        state_d   = S_SWAP_W;
      end

      S_SWAP_W: begin
        // same index twice writes the entry back unchanged
        mem_we    = 1'b1;
        mem_waddr = end_q;
        mem_wdata = tmp_q;
        res_ok_d  = 1'b1;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_rd_d    = res_rd_q;
          out_pos_d   = res_pos_q;
          out_cnt_d   = cnt_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      end_q       <= '0;
      val_q       <= '0;
      tmp_q       <= '0;
      res_ok_q    <= 1'b0;
      res_rd_q    <= '0;
      res_pos_q   <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_rd_q    <= '0;
      out_pos_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      end_q       <= end_d;
      val_q       <= val_d;
      tmp_q       <= tmp_d;
      res_ok_q    <= res_ok_d;
      res_rd_q    <= res_rd_d;
      res_pos_q   <= res_pos_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_rd_q    <= out_rd_d;
      out_pos_q   <= out_pos_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  // element store
  ilte_ram #(
    .WIDTH (ilte_pkg::ValueW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // requests are taken only between items
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_ok_q;
  assign read_value_o     = out_rd_q;
  assign found_position_o = out_pos_q;
  assign count_now_o      = out_cnt_q;

endmodule

### src/ilte_ram.sv
// ----------------------------------------------------------------------------
// ilte_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ilte_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ilte_checker.sv
// ----------------------------------------------------------------------------
// ilte_checker
// port-level assertions for the indexed list table engine
// ----------------------------------------------------------------------------
module ilte_checker #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic [ilte_pkg::FuncW-1:0]            func_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic                                  ok_o,
  input logic signed [ilte_pkg::ValueW-1:0]    read_value_o,
  input logic [$clog2(STORE_DEPTH)-1:0]        found_position_o,
  input logic [$clog2(STORE_DEPTH+1)-1:0]      count_now_o
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);

  logic in_beat;
  logic clear_beat;

  assign in_beat    = in_valid_i && !in_stall_o;
  assign clear_beat = in_beat && (func_i == ilte_pkg::FUNC_CLEAR);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o)
      && $stable(read_value_o) && $stable(found_position_o) && $stable(count_now_o))
    else $error("stalled result beat changed");

  // one request at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // count never exceeds the store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_now_o <= CntW'(STORE_DEPTH))
    else $error("count beyond store depth");

  // a miss never reports a position
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> found_position_o == '0)
    else $error("failed request with nonzero position");

  // a clear accepted while the output is empty succeeds with an empty list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_beat && !out_valid_o ##2 1'b1 |-> out_valid_o && ok_o && count_now_o == '0)
    else $error("clear did not empty the list");

endmodule

bind indexed_list_table_engine_core ilte_checker #(
  .STORE_DEPTH (STORE_DEPTH)
) u_ilte_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .func_i           (func_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .ok_o             (ok_o),
  .read_value_o     (read_value_o),
  .found_position_o (found_position_o),
  .count_now_o      (count_now_o)
);
